// ===== src/tgpr_pkg.sv =====
// tgpr_pkg: shared types, constants and font functions for the glyph pixel renderer.
// No dependencies; used by every module of the block.
package tgpr_pkg;

	localparam int COORD_BITS  = 10;
	localparam int GLYPH_COLS  = 5;
	localparam int GLYPH_ROWS  = 7;
	localparam int GLYPH_BITS  = GLYPH_COLS * GLYPH_ROWS;
	localparam int COL_BITS    = $clog2(GLYPH_COLS);
	localparam int ROW_BITS    = $clog2(GLYPH_ROWS);
	localparam int BIT_BITS    = $clog2(GLYPH_BITS);
	localparam int GLYPH_CNT   = 39;
	localparam int IDX_BITS    = $clog2(GLYPH_CNT);
	localparam int QUEUE_DEPTH = 2;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [IDX_BITS-1:0]   glyph_idx_t;
	typedef logic [GLYPH_BITS-1:0] glyph_bits_t;

	localparam coord_t COORD_MAX = {COORD_BITS{1'b1}};
	localparam coord_t ADVANCE_X = coord_t'(6);
	localparam coord_t ADVANCE_Y = coord_t'(8);

	localparam glyph_idx_t IDX_COLON    = glyph_idx_t'(10);
	localparam glyph_idx_t IDX_SEMI     = glyph_idx_t'(11);
	localparam glyph_idx_t IDX_SPACE    = glyph_idx_t'(12);
	localparam glyph_idx_t IDX_LETTER_A = glyph_idx_t'(13);

	localparam logic [7:0] CODE_NEWLINE = 8'h0A;
	localparam logic [7:0] CODE_ZERO    = 8'h30;
	localparam logic [7:0] CODE_NINE    = 8'h39;
	localparam logic [7:0] CODE_COLON   = 8'h3A;
	localparam logic [7:0] CODE_SEMI    = 8'h3B;
	localparam logic [7:0] CODE_UPPER_A = 8'h41;
	localparam logic [7:0] CODE_UPPER_Z = 8'h5A;
	localparam logic [7:0] CODE_LOWER_A = 8'h61;
	localparam logic [7:0] CODE_LOWER_Z = 8'h7A;

	typedef struct packed {
		logic [7:0] char_code;
		logic       start_string;
		coord_t     origin_x;
		coord_t     origin_y;
		logic [7:0] ink_color;
	} in_word_t;

	typedef struct packed {
		coord_t     pixel_x;
		coord_t     pixel_y;
		logic [7:0] pixel_color;
		logic       last_pixel;
	} out_word_t;

	typedef struct packed {
		glyph_idx_t glyph_idx;
		coord_t     base_x;
		coord_t     base_y;
		logic [7:0] color;
	} cmd_t;

	function automatic coord_t sat_add(input coord_t base, input coord_t step);
		logic [COORD_BITS:0] s;
		s = {1'b0, base} + {1'b0, step};
		return s[COORD_BITS] ? COORD_MAX : s[COORD_BITS-1:0];
	endfunction

	function automatic glyph_idx_t glyph_index(input logic [7:0] code);
		logic [7:0] d;
		d = 8'h00;
		if (code >= CODE_ZERO && code <= CODE_NINE) begin
			d = code - CODE_ZERO;
			return glyph_idx_t'(d);
		end
		if (code >= CODE_UPPER_A && code <= CODE_UPPER_Z) begin
			d = code - CODE_UPPER_A;
			return IDX_LETTER_A + glyph_idx_t'(d);
		end
		if (code >= CODE_LOWER_A && code <= CODE_LOWER_Z) begin
			d = code - CODE_LOWER_A;
			return IDX_LETTER_A + glyph_idx_t'(d);
		end
		if (code == CODE_COLON) return IDX_COLON;
		if (code == CODE_SEMI) return IDX_SEMI;
		return IDX_SPACE;
	endfunction

	// column c occupies bits [c*7 +: 7], row 0 at the lowest bit
	function automatic glyph_bits_t pack5(input logic [7:0] c0, input logic [7:0] c1,
		input logic [7:0] c2, input logic [7:0] c3, input logic [7:0] c4);
		return {c4[6:0], c3[6:0], c2[6:0], c1[6:0], c0[6:0]};
	endfunction

	function automatic glyph_bits_t glyph_font(input glyph_idx_t idx);
		glyph_bits_t g;
		case (idx)
			6'd0:  g = pack5(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
			6'd1:  g = pack5(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
			6'd2:  g = pack5(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
			6'd3:  g = pack5(8'h21, 8'h41, 8'h45, 8'h4B, 8'h31);
			6'd4:  g = pack5(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
			6'd5:  g = pack5(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
			6'd6:  g = pack5(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30);
			6'd7:  g = pack5(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
			6'd8:  g = pack5(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
			6'd9:  g = pack5(8'h06, 8'h49, 8'h49, 8'h29, 8'h1E);
			6'd10: g = pack5(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);
			6'd11: g = pack5(8'h00, 8'h56, 8'h36, 8'h00, 8'h00);
			6'd13: g = pack5(8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E);
			6'd14: g = pack5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
			6'd15: g = pack5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
			6'd16: g = pack5(8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C);
			6'd17: g = pack5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
			6'd18: g = pack5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01);
			6'd19: g = pack5(8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A);
			6'd20: g = pack5(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
			6'd21: g = pack5(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
			6'd22: g = pack5(8'h20, 8'h40, 8'h41, 8'h3F, 8'h01);
			6'd23: g = pack5(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
			6'd24: g = pack5(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
			6'd25: g = pack5(8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F);
			6'd26: g = pack5(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
			6'd27: g = pack5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
			6'd28: g = pack5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
			6'd29: g = pack5(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E);
			6'd30: g = pack5(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
			6'd31: g = pack5(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
			6'd32: g = pack5(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
			6'd33: g = pack5(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
			6'd34: g = pack5(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
			6'd35: g = pack5(8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F);
			6'd36: g = pack5(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
			6'd37: g = pack5(8'h07, 8'h08, 8'h70, 8'h08, 8'h07);
			6'd38: g = pack5(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);
			default: g = '0;
		endcase
		return g;
	endfunction

endpackage

// ===== src/tgpr_front.sv =====
// tgpr_front: accepts character words, keeps the text cursor and margin, and
// issues one draw command per visible glyph. Depends on tgpr_pkg.
module tgpr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  tgpr_pkg::in_word_t item,
	input  logic              accept,
	output logic              cmd_push,
	output tgpr_pkg::cmd_t    cmd
);

	tgpr_pkg::coord_t cursor_col_q, cursor_row_q, left_margin_q;
	tgpr_pkg::coord_t col_eff, row_eff, margin_eff;
	tgpr_pkg::glyph_idx_t idx;
	logic is_newline;

	always_comb begin
		col_eff    = item.start_string ? item.origin_x : cursor_col_q;
		row_eff    = item.start_string ? item.origin_y : cursor_row_q;
		margin_eff = item.start_string ? item.origin_x : left_margin_q;
		is_newline = (item.char_code == tgpr_pkg::CODE_NEWLINE);
		idx        = tgpr_pkg::glyph_index(item.char_code);
		cmd.glyph_idx = idx;
		cmd.base_x    = col_eff;
		cmd.base_y    = row_eff;
		cmd.color     = item.ink_color;
		cmd_push   = accept && !is_newline && (idx != tgpr_pkg::IDX_SPACE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_col_q  <= '0;
			cursor_row_q  <= '0;
			left_margin_q <= '0;
		end else if (accept) begin
			left_margin_q <= margin_eff;
			if (is_newline) begin
				cursor_row_q <= tgpr_pkg::sat_add(row_eff, tgpr_pkg::ADVANCE_Y);
				cursor_col_q <= margin_eff;
			end else begin
				cursor_row_q <= row_eff;
				cursor_col_q <= tgpr_pkg::sat_add(col_eff, tgpr_pkg::ADVANCE_X);
			end
		end
	end

endmodule

// ===== src/tgpr_cmd_queue.sv =====
// tgpr_cmd_queue: short command queue between the front and the pixel scanner.
// Depends on tgpr_pkg.
module tgpr_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tgpr_pkg::cmd_t wdata,
	output logic           full,
	input  logic           pop,
	output tgpr_pkg::cmd_t rdata,
	output logic           empty
);

	localparam int PTR_BITS = (tgpr_pkg::QUEUE_DEPTH > 1) ? $clog2(tgpr_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(tgpr_pkg::QUEUE_DEPTH + 1);
	localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(tgpr_pkg::QUEUE_DEPTH - 1);
	localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(tgpr_pkg::QUEUE_DEPTH);

	tgpr_pkg::cmd_t mem_q [tgpr_pkg::QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic do_push, do_pop;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/tgpr_back.sv =====
// tgpr_back: scans a glyph column by column, top row first, and emits one
// pixel word per lit on-screen bit through an output register. Depends on tgpr_pkg.
module tgpr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  tgpr_pkg::cmd_t     cmd,
	input  logic               cmd_empty,
	output logic               cmd_pop,
	output tgpr_pkg::out_word_t pixel,
	output logic               empty,
	input  logic               pop
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} back_state_t;

	localparam logic [tgpr_pkg::ROW_BITS-1:0] ROW_LAST =
		tgpr_pkg::ROW_BITS'(tgpr_pkg::GLYPH_ROWS - 1);

	back_state_t state_q;
	tgpr_pkg::glyph_bits_t mask_q, load_mask, glyph, rest;
	logic [tgpr_pkg::COL_BITS-1:0] col_q;
	logic [tgpr_pkg::ROW_BITS-1:0] row_q;
	logic [tgpr_pkg::BIT_BITS-1:0] bit_q;
	tgpr_pkg::coord_t base_x_q, base_y_q;
	logic [7:0] color_q;
	tgpr_pkg::out_word_t out_q;
	logic out_valid_q;
	logic advance, lit;
	logic [tgpr_pkg::GLYPH_COLS-1:0] col_ok;
	logic [tgpr_pkg::GLYPH_ROWS-1:0] row_ok;

	assign empty   = !out_valid_q;
	assign pixel   = out_q;
	assign advance = !out_valid_q || pop;
	assign cmd_pop = (state_q == ST_IDLE) && !cmd_empty;

	// drop bits whose pixel would fall beyond the last coordinate
	always_comb begin
		glyph = tgpr_pkg::glyph_font(cmd.glyph_idx);
		for (int c = 0; c < tgpr_pkg::GLYPH_COLS; c++) begin
			col_ok[c] = ({1'b0, cmd.base_x} + (tgpr_pkg::COORD_BITS+1)'(c))
				<= {1'b0, tgpr_pkg::COORD_MAX};
		end
		for (int r = 0; r < tgpr_pkg::GLYPH_ROWS; r++) begin
			row_ok[r] = ({1'b0, cmd.base_y} + (tgpr_pkg::COORD_BITS+1)'(r))
				<= {1'b0, tgpr_pkg::COORD_MAX};
		end
		for (int c = 0; c < tgpr_pkg::GLYPH_COLS; c++) begin
			for (int r = 0; r < tgpr_pkg::GLYPH_ROWS; r++) begin
				load_mask[c*tgpr_pkg::GLYPH_ROWS + r] =
					glyph[c*tgpr_pkg::GLYPH_ROWS + r] && col_ok[c] && row_ok[r];
			end
		end
	end

	always_comb begin
		lit  = mask_q[bit_q];
		rest = mask_q;
		rest[bit_q] = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			base_x_q <= cmd.base_x;
			base_y_q <= cmd.base_y;
			color_q  <= cmd.color;
		end
		if (state_q == ST_SCAN && advance && lit) begin
			out_q.pixel_x     <= base_x_q + tgpr_pkg::coord_t'(col_q);
			out_q.pixel_y     <= base_y_q + tgpr_pkg::coord_t'(row_q);
			out_q.pixel_color <= color_q;
			out_q.last_pixel  <= (rest == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mask_q      <= '0;
			col_q       <= '0;
			row_q       <= '0;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						out_valid_q <= 1'b0;
					end
					if (cmd_pop && load_mask != '0) begin
						mask_q  <= load_mask;
						col_q   <= '0;
						row_q   <= '0;
						bit_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (advance) begin
						out_valid_q <= lit;
						mask_q      <= rest;
						bit_q       <= bit_q + 1'b1;
						if (row_q == ROW_LAST) begin
							row_q <= '0;
							col_q <= col_q + 1'b1;
						end else begin
							row_q <= row_q + 1'b1;
						end
						if (rest == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/text_glyph_pixel_renderer.sv =====
// Each accepted character word is classified by the front, which moves the
// cursor at once; a glyph is then loaded into the scanner, which steps through
// the glyph bit positions one bit per cycle while its output is not stalled, up
// to its last lit on-screen pixel. Newlines, spaces and unknown codes are
// handled at the front alone and emit nothing. A two-entry command queue lets
// the front take further words while the scanner is busy.
// Depends on tgpr_pkg, tgpr_front, tgpr_cmd_queue and tgpr_back.
module text_glyph_pixel_renderer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  tgpr_pkg::in_word_t  item,
	output logic                empty,
	input  logic                pop,
	output tgpr_pkg::out_word_t pixel
);

	logic q_push, q_full, q_pop, q_empty;
	tgpr_pkg::cmd_t q_wdata, q_rdata;

	assign full = q_full;

	tgpr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.accept   (push && !q_full),
		.cmd_push (q_push),
		.cmd      (q_wdata)
	);

	tgpr_cmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	tgpr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (q_rdata),
		.cmd_empty (q_empty),
		.cmd_pop   (q_pop),
		.pixel     (pixel),
		.empty     (empty),
		.pop       (pop)
	);

endmodule
